// ----- rtl/mono_framebuffer_draw_engine_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the draw engine checker
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH

// Checked at every clock edge, reset included.
`define MFDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define MFDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/mfde_pkg.sv -----
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and codes of the framebuffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfde_pkg;

  // command modes as they arrive on the port
  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_VRUN  = 3'd2;
  localparam logic [2:0] MODE_HRUN  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;
  localparam logic [2:0] MODE_PAGE  = 3'd5;

  // work kinds handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RUN_V,
    OP_RUN_H,
    OP_PIX,
    OP_PAGE,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_READ,
    ST_DONE
  } state_t;

  // one classified command: start pixel, number of accesses
  typedef struct packed {
    op_t        op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [8:0] count;
    logic [7:0] color;
    logic       ok;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mfde_if.sv -----
// ----------------------------------------------------------------------------
// mfde_cmd_if / mfde_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfde_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  logic [7:0] end_coord;
  logic [7:0] color;

  modport source (output valid, mode, x_coord, y_coord, end_coord, color, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, end_coord, color, output ready);
endinterface

interface mfde_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       in_range;

  modport source (output valid, read_value, in_range, input ready);
  modport sink   (input valid, read_value, in_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/mfde_ram.sv -----
// ----------------------------------------------------------------------------
// mfde_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8192,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/mfde_front.sv -----
// ----------------------------------------------------------------------------
// mfde_front
// Takes command beats, range-checks and clips them, pushes work to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_front #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  mfde_cmd_if.sink         cmd,
  input  wire logic        init_busy,
  input  wire logic        q_full,
  output      logic        q_push,
  output      mfde_pkg::cmd_t q_data
);
  import mfde_pkg::*;

  localparam logic [8:0]  W9  = 9'(WIDTH);
  localparam logic [8:0]  H9  = 9'(HEIGHT);
  localparam logic [10:0] H11 = 11'(HEIGHT);

  logic [8:0]  x9, y9, e9;
  logic        ok_px, ok_pg;
  logic [8:0]  v_last, h_last, v_cnt, h_cnt, pg_cnt;
  logic [10:0] row11, rem11;

  assign cmd.ready = !q_full && !init_busy;
  assign q_push    = cmd.valid && cmd.ready;

  always_comb begin
    x9 = {1'b0, cmd.x_coord};
    y9 = {1'b0, cmd.y_coord};
    e9 = {1'b0, cmd.end_coord};
    ok_px = (x9 < W9) && (y9 < H9);

    // runs clip at the last row/column; empty when end precedes start
    v_last = (e9 < H9) ? e9 : H9 - 9'd1;
    h_last = (e9 < W9) ? e9 : W9 - 9'd1;
    v_cnt  = (v_last >= y9) ? v_last - y9 + 9'd1 : 9'd0;
    h_cnt  = (h_last >= x9) ? h_last - x9 + 9'd1 : 9'd0;

    // page: up to eight rows, fewer at the bottom edge
    row11  = {cmd.y_coord, 3'b000};
    ok_pg  = (x9 < W9) && (row11 < H11);
    rem11  = H11 - row11;
    pg_cnt = (rem11 >= 11'd8) ? 9'd8 : rem11[8:0];

    q_data.op    = OP_NONE;
    q_data.x_pos = cmd.x_coord;
    q_data.y_pos = cmd.y_coord;
    q_data.count = 9'd1;
    q_data.color = cmd.color;
    q_data.ok    = ok_px;

    unique case (cmd.mode)
      MODE_WRITE: begin
        if (ok_px) q_data.op = OP_RUN_V;
      end
      MODE_READ: begin
        if (ok_px) q_data.op = OP_PIX;
      end
      MODE_VRUN: begin
        q_data.count = v_cnt;
        if (ok_px && v_cnt != 9'd0) q_data.op = OP_RUN_V;
      end
      MODE_HRUN: begin
        q_data.count = h_cnt;
        if (ok_px && h_cnt != 9'd0) q_data.op = OP_RUN_H;
      end
      MODE_CLEAR: begin
        q_data.op = OP_CLEAR;
      end
      MODE_PAGE: begin
        q_data.ok    = ok_pg;
        q_data.y_pos = row11[7:0];
        q_data.count = pg_cnt;
        if (ok_pg) q_data.op = OP_PAGE;
      end
      default: begin
        q_data.ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mfde_queue.sv -----
// ----------------------------------------------------------------------------
// mfde_queue
// Two-entry FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mfde_pkg::cmd_t push_data,
  output      logic           full,
  input  wire logic           pop,
  output      logic           valid,
  output      mfde_pkg::cmd_t head
);
  import mfde_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] used;

  assign full  = (used == 2'd2);
  assign valid = (used != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mfde_back.sv -----
// ----------------------------------------------------------------------------
// mfde_back
// Sequencer that carries out queued commands on the pixel RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_back #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64,
  localparam int DEPTH  = WIDTH * HEIGHT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire mfde_pkg::cmd_t    q_head,
  output      logic              q_pop,
  output      logic              init_busy,
  output      logic              ram_we,
  output      logic [ADDR_W-1:0] ram_waddr,
  output      logic [7:0]        ram_wdata,
  output      logic [ADDR_W-1:0] ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  mfde_res_if.source             res
);
  import mfde_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] STEP_H    = ADDR_W'(HEIGHT);

  state_t            state, state_next;
  logic              init, init_next;
  logic              rd_pend, rd_pend_next;
  logic              out_valid, out_valid_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [8:0]        cnt, cnt_next;
  logic [2:0]        idx, idx_next, rd_idx, rd_idx_next;
  op_t               op, op_next;
  logic [7:0]        color, color_next, value, value_next;
  logic              ok, ok_next;
  logic [7:0]        out_value, out_value_next;
  logic              out_in_range, out_in_range_next;

  assign init_busy      = init;
  assign res.valid      = out_valid;
  assign res.read_value = out_value;
  assign res.in_range   = out_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init      <= 1'b1;
      addr      <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init      <= init_next;
      addr      <= addr_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt          <= cnt_next;
    idx          <= idx_next;
    rd_idx       <= rd_idx_next;
    op           <= op_next;
    color        <= color_next;
    value        <= value_next;
    ok           <= ok_next;
    out_value    <= out_value_next;
    out_in_range <= out_in_range_next;
  end

  always_comb begin
    state_next        = state;
    init_next         = init;
    addr_next         = addr;
    cnt_next          = cnt;
    idx_next          = idx;
    rd_pend_next      = 1'b0;
    rd_idx_next       = idx;
    op_next           = op;
    color_next        = color;
    value_next        = value;
    ok_next           = ok;
    out_valid_next    = out_valid && !res.ready;
    out_value_next    = out_value;
    out_in_range_next = out_in_range;
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = addr;
    ram_wdata         = color;
    ram_raddr         = addr;

    unique case (state)
      ST_CLEAR: begin
        // one entry per cycle; also the pass that follows reset
        ram_we    = 1'b1;
        ram_wdata = 8'd0;
        addr_next = addr + ADDR_W'(1);
        if (addr == LAST_ADDR) begin
          addr_next = '0;
          init_next = 1'b0;
          state_next = init ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_next    = q_head.op;
          color_next = q_head.color;
          ok_next    = q_head.ok;
          cnt_next   = q_head.count;
          idx_next   = 3'd0;
          value_next = 8'd0;
          // column-major store: column * HEIGHT + row
          addr_next  = ADDR_W'(q_head.x_pos) * STEP_H + ADDR_W'(q_head.y_pos);
          unique case (q_head.op)
            OP_RUN_V, OP_RUN_H: state_next = ST_RUN;
            OP_PIX, OP_PAGE:    state_next = ST_READ;
            OP_CLEAR: begin
              addr_next  = '0;
              state_next = ST_CLEAR;
            end
            default:            state_next = ST_DONE;
          endcase
        end
      end
      ST_RUN: begin
        ram_we    = 1'b1;
        addr_next = addr + ((op == OP_RUN_H) ? STEP_H : ADDR_W'(1));
        cnt_next  = cnt - 9'd1;
        if (cnt == 9'd1) state_next = ST_DONE;
      end
      ST_READ: begin
        // issue one row per cycle, capture the data in the cycle after
        if (cnt != 9'd0) begin
          addr_next    = addr + ADDR_W'(1);
          cnt_next     = cnt - 9'd1;
          idx_next     = idx + 3'd1;
          rd_pend_next = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
        if (rd_pend) begin
          if (op == OP_PIX) value_next = ram_rdata;
          else              value_next[rd_idx] = (ram_rdata == 8'd1);
        end
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          out_valid_next    = 1'b1;
          out_value_next    = value;
          out_in_range_next = ok;
          state_next        = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mono_framebuffer_draw_engine_unit.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit
// The back-end sequencer carries out one command at a time; commands do not
//   overlap in the back end.
// Reset: synchronous; then a pass zeroes the pixel RAM with cmd.ready held low.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure:
//   front  - classifies a command beat: range check, run clipping, access
//            count; no RAM access; stalls on a full queue or the clear pass.
//   queue  - two entries, lets the front keep taking beats while the back
//            end works or its result beat waits.
//   back   - FSM walking the RAM one access per cycle, waiting while a result
//            beat stalls; holds the result register that drives the res channel.
//   ram    - pixel store, column-major, one byte per pixel.
module mono_framebuffer_draw_engine_unit #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mfde_cmd_if.sink   cmd,
  mfde_res_if.source res
);
  import mfde_pkg::*;

  localparam int DEPTH  = WIDTH * HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              q_push, q_full, q_pop, q_valid, init_busy;
  cmd_t              q_data, q_head;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  mfde_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .cmd       (cmd),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  mfde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  mfde_back #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  // pixel store; read data lands in the cycle after the address
  mfde_ram #(
    .DATA_W (8),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/mfde_checker.sv -----
// ----------------------------------------------------------------------------
// mfde_checker
// Port-level checks on the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_framebuffer_draw_engine_unit_macros.svh"

module mfde_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] read_value,
  input wire logic       in_range
);

  // commands taken whose result beat has not gone out yet
  logic [2:0] pend;
  logic       cmd_beat, res_beat;

  assign cmd_beat = cmd_valid && cmd_ready;
  assign res_beat = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else begin
      pend <= pend + {2'b00, cmd_beat} - {2'b00, res_beat};
    end
  end

  // RAM clearing pass holds off commands right after reset
  `MFDE_ASSERT_ALWAYS(a_init_hold, $past(rst) |-> !cmd_ready, "command taken during clear pass")
  `MFDE_ASSERT_ALWAYS(a_res_reset, $past(rst) |-> !res_valid, "result valid out of reset")
  `MFDE_ASSERT(a_no_orphan, res_valid |-> pend != 3'd0, "result with no pending command")
  // queue, sequencer and result register: four commands at most in flight
  `MFDE_ASSERT(a_pend_cap, pend <= 3'd4, "more commands in flight than storage")
  `MFDE_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(read_value) && $stable(in_range), "stalled result changed")

endmodule

bind mono_framebuffer_draw_engine_unit mfde_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .read_value (res.read_value),
  .in_range   (res.in_range)
);

`default_nettype wire

// ----- tb/sv/mfde_draw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_draw_checker
// Watches the command and result channels of the draw engine, keeps its own
// copy of the pixel store, predicts one result per command beat and compares
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module mfde_draw_checker
  import mfde_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic clk,
  input  logic rst,
  mfde_cmd_if  cmd,
  mfde_res_if  res,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [7:0] read_value;
    logic       in_range;
  } draw_result_t;

  logic [7:0]   pixel_mirror [WIDTH*HEIGHT];
  draw_result_t pending_results [$];
  int           result_beats;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    result_beats = 0;
    foreach (pixel_mirror[k]) pixel_mirror[k] = 8'd0;
  end

  // applies one command to the mirror and returns what the block should answer
  task automatic predict_draw(input logic [2:0] mode, input logic [7:0] x_in,
                              input logic [7:0] y_in, input logic [7:0] end_in,
                              input logic [7:0] color, output draw_result_t r);
    int   xi;
    int   yi;
    int   ei;
    int   i;
    int   row;
    logic ok;
    logic [7:0] value;
    xi    = x_in;
    yi    = y_in;
    ei    = end_in;
    value = 8'd0;
    ok    = (xi < WIDTH) && (yi < HEIGHT);
    case (mode)
      MODE_WRITE: if (ok) pixel_mirror[xi*HEIGHT + yi] = color;
      MODE_READ:  if (ok) value = pixel_mirror[xi*HEIGHT + yi];
      MODE_VRUN: begin
        if (ok)
          for (i = yi; i <= ei && i < HEIGHT; i++) pixel_mirror[xi*HEIGHT + i] = color;
      end
      MODE_HRUN: begin
        if (ok)
          for (i = xi; i <= ei && i < WIDTH; i++) pixel_mirror[i*HEIGHT + yi] = color;
      end
      MODE_CLEAR: foreach (pixel_mirror[k]) pixel_mirror[k] = 8'd0;
      MODE_PAGE: begin
        ok = (xi < WIDTH) && (yi * 8 < HEIGHT);
        if (ok)
          for (i = 0; i < 8; i++) begin
            row = yi * 8 + i;
            if (row < HEIGHT && pixel_mirror[xi*HEIGHT + row] == 8'd1) value[i] = 1'b1;
          end
      end
      default: ok = 1'b0;
    endcase
    r.read_value = value;
    r.in_range   = ok;
  endtask

  task automatic report_mismatch(input string what, input int expected, input int actual);
    $display("[%0t] result beat %0d: %s expected %0d got %0d",
             $time, result_beats, what, expected, actual);
    fail_count++;
  endtask

  always @(posedge clk) begin
    draw_result_t want;
    draw_result_t fresh;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat, in_range", -1, res.in_range);
        end else begin
          want = pending_results.pop_front();
          if (res.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, res.read_value);
          if (res.in_range !== want.in_range)
            report_mismatch("in_range", want.in_range, res.in_range);
        end
        result_beats++;
      end
      if (cmd.valid && cmd.ready) begin
        predict_draw(cmd.mode, cmd.x_coord, cmd.y_coord, cmd.end_coord, cmd.color, fresh);
        pending_results.push_back(fresh);
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_mono_framebuffer_draw_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine_unit
// Drives directed and random draw commands into the engine with random idle
// and backpressure bursts; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine_unit;
  import mfde_pkg::*;

  localparam int WIDTH      = 128;
  localparam int HEIGHT     = 64;
  localparam int NUM_RANDOM = 1900;
  localparam int QUIET_FROM = 1700;     // last stretch runs without idling
  localparam int DRAIN_AT   = 600;      // sender holds until all results are back
  localparam int LIMIT      = 2000000;  // cycles, well above the slowest legal run
  localparam int TAIL       = 20;       // cycles after the last result

  logic clk;
  logic rst;
  logic no_idle;
  int   fail_count;
  int   outstanding;
  int   cycle_count;

  mfde_cmd_if cmd_ch ();
  mfde_res_if res_ch ();

  mono_framebuffer_draw_engine_unit #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  mfde_draw_checker #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: covers a hung handshake and results that never come back.
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("[%0t] timeout with %0d results outstanding", $time, outstanding);
    $display("FAILURE");
    $finish;
  end

  // Result side backpressure: ready-high bursts, now and then long ones,
  // separated by ready-low stalls until the quiet tail of the run.
  initial begin
    int span;
    res_ch.ready = 1'b0;
    forever begin
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (span) begin
        @(negedge clk);
        res_ch.ready <= 1'b1;
      end
      if (!no_idle) begin
        span = $urandom_range(1, 10);
        repeat (span) begin
          @(negedge clk);
          res_ch.ready <= 1'b0;
        end
      end
    end
  end

  // One command beat: set up at the falling edge, held until accepted.
  // valid stays high on return so back-to-back beats need no extra assignment.
  task automatic issue_cmd(input logic [2:0] mode, input int x, input int y,
                           input int e, input int c);
    @(negedge clk);
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= mode;
    cmd_ch.x_coord   <= x[7:0];
    cmd_ch.y_coord   <= y[7:0];
    cmd_ch.end_coord <= e[7:0];
    cmd_ch.color     <= c[7:0];
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Coordinates: half the time a small hot corner so reads hit drawn pixels,
  // often anywhere on screen, sometimes the full 8-bit range.
  function automatic int pick_coord(input int span);
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return $urandom_range(0, 15);
    if (r < 7) return $urandom_range(0, span - 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_color();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 1);
    return $urandom_range(0, 255);
  endfunction

  // run end: usually a short run from the start, else anything
  // (covers end before start and runs off the edge)
  function automatic int pick_end(input int start, input int reach);
    int e;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    e = start + $urandom_range(0, reach);
    return (e > 255) ? 255 : e;
  endfunction

  initial begin
    int       done;
    int       r;
    int       x;
    int       y;
    int       gap_pct;
    logic [2:0] mode;

    rst              = 1'b1;
    no_idle          = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.mode      = MODE_WRITE;
    cmd_ch.x_coord   = 8'd0;
    cmd_ch.y_coord   = 8'd0;
    cmd_ch.end_coord = 8'd0;
    cmd_ch.color     = 8'd0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // ready stays low during the clearing pass; the handshake waits it out

    // ---- directed part ----
    issue_cmd(MODE_READ,  0,   0,   0,   0);    // fresh store reads zero
    issue_cmd(MODE_WRITE, 0,   0,   0,   1);
    issue_cmd(MODE_WRITE, 127, 63,  0,   255);  // far corner
    issue_cmd(MODE_READ,  127, 63,  0,   0);
    issue_cmd(MODE_WRITE, 128, 0,   0,   7);    // column just off screen
    issue_cmd(MODE_WRITE, 0,   64,  0,   7);    // row just off screen
    issue_cmd(MODE_READ,  128, 0,   0,   0);
    issue_cmd(MODE_READ,  255, 255, 0,   0);
    issue_cmd(MODE_VRUN,  5,   58,  255, 1);    // clipped at bottom edge
    issue_cmd(MODE_VRUN,  6,   20,  10,  1);    // end before start: no draw
    issue_cmd(MODE_HRUN,  120, 3,   255, 1);    // clipped at right edge
    issue_cmd(MODE_HRUN,  10,  4,   5,   9);    // end before start
    issue_cmd(MODE_WRITE, 5,   60,  0,   2);    // nonzero but not 1: page bit stays 0
    issue_cmd(MODE_PAGE,  5,   7,   0,   0);
    issue_cmd(MODE_PAGE,  127, 0,   0,   0);
    issue_cmd(MODE_PAGE,  5,   8,   0,   0);    // page past the bottom
    issue_cmd(MODE_PAGE,  128, 0,   0,   0);    // column off screen
    issue_cmd(MODE_PAGE,  5,   255, 0,   0);    // page index far out
    issue_cmd(3'd6,       1,   1,   1,   1);    // unused modes
    issue_cmd(3'd7,       1,   1,   1,   1);
    issue_cmd(MODE_VRUN,  0,   0,   63,  255);  // full column
    issue_cmd(MODE_HRUN,  0,   63,  127, 1);    // full bottom row
    issue_cmd(MODE_PAGE,  0,   7,   0,   0);
    issue_cmd(MODE_CLEAR, 200, 3,   0,   0);    // clear with start off screen
    issue_cmd(MODE_READ,  127, 63,  0,   0);
    wait_drained();

    // ---- random part ----
    done    = 0;
    gap_pct = 25;
    while (done < NUM_RANDOM) begin
      if (done % 64 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (done >= QUIET_FROM) no_idle = 1'b1;
      if (done == DRAIN_AT) wait_drained();
      if (!no_idle && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 10));

      r = $urandom_range(0, 999);
      if      (r < 300) mode = MODE_WRITE;
      else if (r < 530) mode = MODE_READ;
      else if (r < 650) mode = MODE_VRUN;
      else if (r < 770) mode = MODE_HRUN;
      else if (r < 975) mode = MODE_PAGE;
      else if (r < 995) mode = 3'($urandom_range(6, 7));
      else              mode = MODE_CLEAR;  // rare: each one sweeps the whole store

      x = pick_coord(WIDTH);
      y = (mode == MODE_PAGE) ? pick_coord(HEIGHT / 8) : pick_coord(HEIGHT);
      case (mode)
        MODE_VRUN: issue_cmd(mode, x, y, pick_end(y, 12), pick_color());
        MODE_HRUN: issue_cmd(mode, x, y, pick_end(x, 24), pick_color());
        default:   issue_cmd(mode, x, y, $urandom_range(0, 255),
                             (mode == MODE_WRITE) ? pick_color() : $urandom_range(0, 255));
      endcase
      // unused modes are noise and do not count toward the item budget
      if (mode < 3'd6) done++;
    end

    // ---- wrap up ----
    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- mono_framebuffer_draw_engine_unit.f -----
+incdir+rtl
rtl/mfde_pkg.sv
rtl/mfde_if.sv
rtl/mfde_ram.sv
rtl/mfde_front.sv
rtl/mfde_queue.sv
rtl/mfde_back.sv
rtl/mono_framebuffer_draw_engine_unit.sv
rtl/mfde_checker.sv
tb/sv/mfde_draw_checker.sv
tb/sv/tb_mono_framebuffer_draw_engine_unit.sv
